>>> hw/rtl/bst_pkg.sv
`timescale 1ns / 1ps

package bst_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int CMP_W  = 5;
    localparam int ECNT_W = 9;
    localparam int VAL_W  = 16;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [VAL_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic              status;
        logic              found;
        logic [CMP_W-1:0]  comparisons;
        logic [ECNT_W-1:0] entry_count;
    } out_t;

endpackage

>>> hw/rtl/binary_search_table_top.sv
`timescale 1ns / 1ps

// Clear, append and the unused code go from idle straight to done, then into the output register.
// A search makes P probes, at most log2(DEPTH)+1 = 9, before it reaches done.
// Each probe is a registered read of the table RAM (PROBE state) and then a compare (CMP state).
// One item at a time; the next item is taken while a finished result waits in the output register.
// Reset (aresetn low, synchronous) empties the table and drops any result; no clearing pass.
module binary_search_table_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bst_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bst_pkg::out_t  m_data
);
    import bst_pkg::*;

    // One-hot sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PROBE = 4'b0010,   // read the middle entry
        ST_CMP   = 4'b0100,   // compare read data with the key
        ST_DONE  = 4'b1000    // result held until the output register is free
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    // Search window is [left, hi): hi is one past the model's right bound,
    // so an empty window never needs a negative value.
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CMP_W-1:0]   miss_reg, miss_next;
    logic [VAL_W-1:0]   key_reg, key_next;
    out_t               res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    // Table RAM, one write port (append) and one registered read port (probe)
    logic [VAL_W-1:0]   table_mem [DEPTH];
    logic [VAL_W-1:0]   rd_data_reg;

    logic               s_xfer;
    logic               tbl_full;
    logic               do_write;
    logic [CNT_W:0]     mid_sum;
    logic [ADDR_W-1:0]  mid;
    logic [CNT_W-1:0]   mid_ext;
    logic               key_lt;
    logic               key_eq;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign tbl_full = (count_reg == CNT_W'(DEPTH));
    assign do_write = s_xfer && (s_data.func == FUNC_APPEND) && !tbl_full;

    // mid = floor((left + right) / 2) with right = hi - 1; only used while left < hi
    assign mid_sum = {1'b0, left_reg} + {1'b0, hi_reg} - (CNT_W + 1)'(1);
    assign mid     = mid_sum[ADDR_W:1];
    assign mid_ext = {1'b0, mid};

    assign key_eq = (key_reg == rd_data_reg);
    assign key_lt = (key_reg <  rd_data_reg);

    always_ff @(posedge aclk) begin
        if (do_write) begin
            table_mem[count_reg[ADDR_W-1:0]] <= s_data.value;
        end
        if (state_reg == ST_PROBE) begin
            rd_data_reg <= table_mem[mid];
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        left_next    = left_reg;
        hi_next      = hi_reg;
        miss_next    = miss_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        // output register drains on its own transfer
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    res_next             = '0;
                    res_next.entry_count = ECNT_W'(count_reg);
                    key_next             = s_data.value;
                    left_next            = '0;
                    hi_next              = count_reg;
                    miss_next            = '0;
                    state_next           = ST_DONE;
                    case (s_data.func)
                        FUNC_CLEAR: begin
                            count_next           = '0;
                            res_next.entry_count = '0;
                        end
                        FUNC_APPEND: begin
                            if (tbl_full) begin
                                res_next.status = 1'b1;
                            end else begin
                                count_next           = count_reg + CNT_W'(1);
                                res_next.entry_count = ECNT_W'(count_reg + CNT_W'(1));
                            end
                        end
                        FUNC_SEARCH: begin
                            // empty table: no probe at all
                            if (count_reg != '0) begin
                                state_next = ST_PROBE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (key_eq) begin
                    res_next.found       = 1'b1;
                    res_next.comparisons = miss_reg;
                    state_next           = ST_DONE;
                end else begin
                    if (key_lt) begin
                        hi_next = mid_ext;
                    end else begin
                        left_next = mid_ext + CNT_W'(1);
                    end
                    miss_next            = miss_reg + CMP_W'(1);
                    res_next.comparisons = miss_reg + CMP_W'(1);
                    if ((key_lt ? left_reg : mid_ext + CNT_W'(1)) <
                        (key_lt ? mid_ext : hi_reg)) begin
                        state_next = ST_PROBE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg   <= left_next;
        hi_reg     <= hi_next;
        miss_reg   <= miss_next;
        key_reg    <= key_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // fill level never passes the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond table depth");

    // a probe is only issued on a non-empty window
    a_probe_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE) |-> (left_reg < hi_reg))
        else $error("probe issued on an empty window");

    // a binary search over the table never misses more than log2(DEPTH)+1 times
    a_miss_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (miss_reg <= CMP_W'(ADDR_W)))
        else $error("too many probes in one search");

    // a finished result is never lost while the output register is stalled
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> (state_reg == ST_DONE))
        else $error("result left before output register freed");

    // the count only moves on an input transfer
    a_count_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_xfer |=> $stable(count_reg))
        else $error("entry count changed without a transfer");

endmodule
